// ===== hdl/t9sm_pkg.sv =====
// Shared types, constants and character classification functions of the T9 subsequence matcher.
package t9sm_pkg;

   localparam int MAX_FIELD   = 100;
   localparam int QUERY_DEPTH = 128;
   localparam int QADDR_W     = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
   localparam int QLEN_W      = $clog2(QUERY_DEPTH + 1);
   localparam int FLEN_W      = 7;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_NAME   = 2'd1,
      CMD_NUMBER = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NUMERIC_NAME = 2'd1,
      STATUS_BAD_NUMBER   = 2'd2,
      STATUS_TOO_LONG     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] char_code;
      logic       has_char;
      logic       field_end;
      logic       numeric;
      logic [7:0] t9_key;
   } item_type;

   function automatic logic numeric_byte(input logic [7:0] c);
      return ((c >= "0") && (c <= "9")) || (c == "+") || (c == " ");
   endfunction

   // Returns the keypad digit of a letter, or zero for any other byte.
   function automatic logic [7:0] t9_key(input logic [7:0] c);
      logic [7:0] l;
      logic       letter;
      l      = c | 8'h20;
      letter = (l >= "a") && (l <= "z");
      if (!letter)        return 8'h00;
      else if (l <= "c")  return "2";
      else if (l <= "f")  return "3";
      else if (l <= "i")  return "4";
      else if (l <= "l")  return "5";
      else if (l <= "o")  return "6";
      else if (l <= "s")  return "7";
      else if (l <= "v")  return "8";
      else                return "9";
   endfunction

endpackage

// ===== hdl/t9_subsequence_matcher.sv =====
// Top level of the T9 subsequence matcher: front stage, request queue and matching back end.
//
// The block takes one request per cycle while req_stall is low: query appends, query clears,
// and the name and number bytes of contact records. Each name or number byte updates the
// greedy match of its own field as it is taken, because the query byte at each match pointer
// is read from its own copy of the query store every cycle at the pointer's next value. While a
// result waits in the output register under stall, the back end holds, and the two-entry queue
// and the front register keep taking requests until they fill. There is no clearing pass after
// reset; query entries are only read once written.
module t9_subsequence_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_char_code,
   input  logic       req_has_char,
   input  logic       req_field_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_record_match,
   output logic [1:0] rsp_status
);

   logic               push;
   t9sm_pkg::item_type push_item;
   logic               queue_full;
   logic               pop;
   logic               queue_valid;
   t9sm_pkg::item_type queue_item;

   t9sm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_has_char  (req_has_char),
      .req_field_end (req_field_end),
      .push          (push),
      .push_item     (push_item),
      .queue_full    (queue_full)
   );

   t9sm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .valid     (queue_valid),
      .item      (queue_item)
   );

   t9sm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (queue_valid),
      .item             (queue_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_match (rsp_record_match),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== hdl/t9sm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module t9sm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/t9sm_front.sv =====
// Front stage: accepts requests and classifies each byte before it is queued.
module t9sm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [7:0]          req_char_code,
   input  logic                req_has_char,
   input  logic                req_field_end,
   output logic                push,
   output t9sm_pkg::item_type  push_item,
   input  logic                queue_full
);

   logic               valid_ff, valid_in;
   t9sm_pkg::item_type item_ff, item_in;
   logic               load;

   assign load      = !valid_ff || !queue_full;
   assign req_stall = !load;
   assign push      = valid_ff && !queue_full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in          = req_valid;
         item_in.cmd       = t9sm_pkg::cmd_type'(req_cmd);
         item_in.char_code = req_char_code;
         item_in.has_char  = req_has_char;
         item_in.field_end = req_field_end;
         item_in.numeric   = t9sm_pkg::numeric_byte(req_char_code);
         item_in.t9_key    = t9sm_pkg::t9_key(req_char_code);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== hdl/t9sm_queue.sv =====
// Two-entry queue between the front stage and the matching back end.
module t9sm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  t9sm_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output t9sm_pkg::item_type  item
);

   t9sm_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/t9sm_back.sv =====
// Back end: query store, both subsequence matches, record checks and the result register.
module t9sm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  t9sm_pkg::item_type  item,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_record_match,
   output logic [1:0]          rsp_status
);

   localparam int QA = t9sm_pkg::QADDR_W;
   localparam int QL = t9sm_pkg::QLEN_W;
   localparam int FL = t9sm_pkg::FLEN_W;

   logic [QL-1:0] qlen_ff, qlen_in;
   logic [QL-1:0] name_ptr_ff, name_ptr_in;
   logic [QL-1:0] num_ptr_ff, num_ptr_in;
   logic [FL-1:0] flen_ff, flen_in;
   logic          all_numeric_ff, all_numeric_in;
   logic          nonempty_ff, nonempty_in;
   logic          bad_char_ff, bad_char_in;
   logic          too_long_ff, too_long_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          match_ff, match_in;
   logic [1:0]    status_ff, status_in;

   logic          wr_en;
   logic [7:0]    name_rdata, num_rdata;
   logic          name_byp_ff, num_byp_ff;
   logic [7:0]    wr_data_ff;
   logic [7:0]    q_name, q_num;
   logic          produce;
   logic          name_hit, num_hit;

   assign pop = item_valid && !(rsp_valid_ff && rsp_stall);

   t9sm_ram #(
      .WIDTH (8),
      .DEPTH (t9sm_pkg::QUERY_DEPTH)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (qlen_ff[QA-1:0]),
      .wr_data (item.char_code),
      .rd_addr (name_ptr_in[QA-1:0]),
      .rd_data (name_rdata)
   );

   t9sm_ram #(
      .WIDTH (8),
      .DEPTH (t9sm_pkg::QUERY_DEPTH)
   ) u_num_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (qlen_ff[QA-1:0]),
      .wr_data (item.char_code),
      .rd_addr (num_ptr_in[QA-1:0]),
      .rd_data (num_rdata)
   );

   assign q_name = name_byp_ff ? wr_data_ff : name_rdata;
   assign q_num  = num_byp_ff ? wr_data_ff : num_rdata;

   assign name_hit = (item.char_code == q_name) ||
                     ((item.t9_key != 8'h00) && (item.t9_key == q_name));
   assign num_hit  = (item.char_code == q_num) ||
                     ((q_num == "0") && (item.char_code == "+"));

   always_comb begin
      qlen_in        = qlen_ff;
      name_ptr_in    = name_ptr_ff;
      num_ptr_in     = num_ptr_ff;
      flen_in        = flen_ff;
      all_numeric_in = all_numeric_ff;
      nonempty_in    = nonempty_ff;
      bad_char_in    = bad_char_ff;
      too_long_in    = too_long_ff;
      wr_en          = 1'b0;
      produce        = 1'b0;
      match_in       = match_ff;
      status_in      = status_ff;
      if (pop) begin
         case (item.cmd)
            t9sm_pkg::CMD_APPEND: begin
               if (item.has_char && (qlen_ff < QL'(t9sm_pkg::QUERY_DEPTH))) begin
                  wr_en   = 1'b1;
                  qlen_in = qlen_ff + 1'b1;
               end
            end
            t9sm_pkg::CMD_CLEAR: begin
               qlen_in = '0;
            end
            t9sm_pkg::CMD_NAME: begin
               if (item.has_char) begin
                  if (flen_ff >= FL'(t9sm_pkg::MAX_FIELD)) begin
                     too_long_in = 1'b1;
                  end else begin
                     flen_in = flen_ff + 1'b1;
                  end
                  nonempty_in = 1'b1;
                  if (!item.numeric) begin
                     all_numeric_in = 1'b0;
                  end
                  if ((name_ptr_ff < qlen_ff) && name_hit) begin
                     name_ptr_in = name_ptr_ff + 1'b1;
                  end
               end
               if (item.field_end) begin
                  flen_in = '0;
               end
            end
            t9sm_pkg::CMD_NUMBER: begin
               if (item.has_char) begin
                  if (flen_ff >= FL'(t9sm_pkg::MAX_FIELD)) begin
                     too_long_in = 1'b1;
                  end else begin
                     flen_in = flen_ff + 1'b1;
                  end
                  if (!item.numeric) begin
                     bad_char_in = 1'b1;
                  end
                  if ((num_ptr_ff < qlen_ff) && num_hit) begin
                     num_ptr_in = num_ptr_ff + 1'b1;
                  end
               end
               if (item.field_end) begin
                  produce  = 1'b1;
                  match_in = (qlen_ff == '0) || (num_ptr_in >= qlen_ff) ||
                             (name_ptr_ff >= qlen_ff);
                  if (too_long_in) begin
                     status_in = t9sm_pkg::STATUS_TOO_LONG;
                  end else if (nonempty_ff && all_numeric_ff) begin
                     status_in = t9sm_pkg::STATUS_NUMERIC_NAME;
                  end else if (bad_char_in) begin
                     status_in = t9sm_pkg::STATUS_BAD_NUMBER;
                  end else begin
                     status_in = t9sm_pkg::STATUS_OK;
                  end
                  name_ptr_in    = '0;
                  num_ptr_in     = '0;
                  flen_in        = '0;
                  all_numeric_in = 1'b1;
                  nonempty_in    = 1'b0;
                  bad_char_in    = 1'b0;
                  too_long_in    = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff        <= '0;
         name_ptr_ff    <= '0;
         num_ptr_ff     <= '0;
         flen_ff        <= '0;
         all_numeric_ff <= 1'b1;
         nonempty_ff    <= 1'b0;
         bad_char_ff    <= 1'b0;
         too_long_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         name_byp_ff    <= 1'b0;
         num_byp_ff     <= 1'b0;
      end else begin
         qlen_ff        <= qlen_in;
         name_ptr_ff    <= name_ptr_in;
         num_ptr_ff     <= num_ptr_in;
         flen_ff        <= flen_in;
         all_numeric_ff <= all_numeric_in;
         nonempty_ff    <= nonempty_in;
         bad_char_ff    <= bad_char_in;
         too_long_ff    <= too_long_in;
         rsp_valid_ff   <= rsp_valid_in;
         name_byp_ff    <= wr_en && (qlen_ff[QA-1:0] == name_ptr_in[QA-1:0]);
         num_byp_ff     <= wr_en && (qlen_ff[QA-1:0] == num_ptr_in[QA-1:0]);
      end
      wr_data_ff <= item.char_code;
      match_ff   <= match_in;
      status_ff  <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_match = match_ff;
   assign rsp_status       = status_ff;

endmodule
